FILE: hw/rtl/greedy_word_wrap_line_breaker_top_macros.svh
// assertion macros for the rtl, used by gwwlb_dp
`ifndef GREEDY_WORD_WRAP_LINE_BREAKER_TOP_MACROS_SVH
`define GREEDY_WORD_WRAP_LINE_BREAKER_TOP_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define GWWLB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define GWWLB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/gwwlb_pkg.sv
package gwwlb_pkg;

    localparam int OUT_INDEX_W = 16;

    typedef logic [7:0] char_t;
    typedef logic [7:0] col_t;
    typedef logic [6:0] tab_t;
    typedef logic [0:0] cfg_index_t;
    typedef logic [7:0] cfg_data_t;

    localparam char_t CHAR_HTAB    = 8'd9;
    localparam char_t CHAR_NEWLINE = 8'd10;
    localparam char_t CHAR_SPACE   = 8'd32;

    localparam col_t LINE_WIDTH_RESET = 8'd40;
    localparam tab_t TAB_STOP_RESET   = 7'd4;

    localparam cfg_index_t CFG_LINE_WIDTH = 1'd0;
    localparam cfg_index_t CFG_TAB_STOP   = 1'd1;

    typedef enum logic [1:0] {
        KIND_NEWLINE = 2'd0,
        KIND_SOFT    = 2'd1,
        KIND_HARD    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        RES_FIT,
        RES_BREAK,
        RES_END
    } step_res_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD_START,
        S_MOD_WAIT,
        S_TRY,
        S_FLUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic rem_start;
        logic try_step;
        logic flush;
    } dp_cmd_t;

    typedef struct packed {
        logic      in_is_tab;
        logic      is_tab;
        step_res_t res;
        logic      can_push;
        logic      out_free;
        logic      rem_done;
    } dp_stat_t;

endpackage

FILE: hw/rtl/gwwlb_if.sv
interface gwwlb_in_if;
    logic                 valid;
    logic                 ready;
    gwwlb_pkg::char_t     character;
    logic                 first_of_text;

    modport source (output valid, output character, output first_of_text, input ready);
    modport sink   (input valid, input character, input first_of_text, output ready);
endinterface

interface gwwlb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] line_start_index;
    logic [1:0]  break_kind;
    logic        last_of_run;

    modport source (output valid, output line_start_index, output break_kind,
                    output last_of_run, input ready);
    modport sink   (input valid, input line_start_index, input break_kind,
                    input last_of_run, output ready);
endinterface

FILE: hw/rtl/gwwlb_rem.sv
module gwwlb_rem (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  gwwlb_pkg::col_t  dividend,
    input  gwwlb_pkg::tab_t  divisor,
    output logic             done,
    output gwwlb_pkg::tab_t  remainder
);
    import gwwlb_pkg::*;

    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [1:0] cnt_reg, cnt_next;
    col_t       dvd_reg, dvd_next;
    tab_t       r_reg, r_next;
    tab_t       r_mid;

    function automatic tab_t rem_step(tab_t r, logic b, tab_t d);
        logic [7:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
        begin
            rem_step = 7'(t - {1'b0, d});
        end
        else
        begin
            rem_step = t[6:0];
        end
    endfunction

    // two restoring steps per cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        r_next    = r_reg;
        r_mid     = rem_step(r_reg, dvd_reg[7], divisor);
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 2'd0;
            dvd_next  = dividend;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            r_next   = rem_step(r_mid, dvd_reg[6], divisor);
            dvd_next = {dvd_reg[5:0], 2'b00};
            cnt_next = cnt_reg + 2'd1;
            if (cnt_reg == 2'd3)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        r_reg   <= r_next;
    end

    assign done      = done_reg;
    assign remainder = r_reg;

endmodule

FILE: hw/rtl/gwwlb_ctrl.sv
module gwwlb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gwwlb_pkg::dp_stat_t st,
    output gwwlb_pkg::dp_cmd_t  cmd
);
    import gwwlb_pkg::*;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = st.in_is_tab ? S_MOD_START : S_TRY;
                end
            end
            S_MOD_START:
            begin
                state_next = S_MOD_WAIT;
            end
            S_MOD_WAIT:
            begin
                if (st.rem_done)
                begin
                    state_next = S_TRY;
                end
            end
            S_TRY:
            begin
                if (st.can_push)
                begin
                    case (st.res)
                        RES_FIT:   state_next = S_IDLE;
                        RES_BREAK: state_next = st.is_tab ? S_MOD_START : S_TRY;
                        RES_END:   state_next = S_FLUSH;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_FLUSH:
            begin
                if (st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_MOD_START:
            begin
                cmd.rem_start = 1'b1;
            end
            S_MOD_WAIT:
            begin
                cmd = '0;
            end
            S_TRY:
            begin
                cmd.try_step = st.can_push;
            end
            S_FLUSH:
            begin
                cmd.flush = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: hw/rtl/gwwlb_dp.sv
`include "greedy_word_wrap_line_breaker_top_macros.svh"

module gwwlb_dp #(
    parameter int INDEX_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  gwwlb_pkg::cfg_index_t cfg_index,
    input  gwwlb_pkg::cfg_data_t  cfg_wdata,
    input  gwwlb_pkg::char_t      in_character,
    input  logic                  in_first,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [15:0]           out_index,
    output logic [1:0]            out_kind,
    output logic                  out_last,
    input  gwwlb_pkg::dp_cmd_t    cmd,
    output gwwlb_pkg::dp_stat_t   st
);
    import gwwlb_pkg::*;

    typedef logic [INDEX_BITS-1:0] idx_t;

    col_t  lw_reg;
    tab_t  ts_reg;

    idx_t  pos_reg, pos_next;
    idx_t  line_reg, line_next;
    col_t  col_reg, col_next;
    idx_t  cand_reg, cand_next;
    logic  cv_reg, cv_next;
    char_t ch_reg, ch_next;
    logic  pend_valid_reg, pend_valid_next;
    idx_t  pend_idx_reg, pend_idx_next;
    kind_t pend_kind_reg, pend_kind_next;
    logic  out_valid_reg, out_valid_next;
    logic [15:0] out_idx_reg, out_idx_next;
    kind_t out_kind_reg, out_kind_next;
    logic  out_last_reg, out_last_next;

    idx_t      idx_p1;
    idx_t      cand_dist;
    tab_t      stop;
    tab_t      rem_val;
    logic      rem_done;
    logic      is_nl, is_tab, is_ws;
    col_t      w;
    logic [8:0] sum;
    logic      fits, soft_ok, hard_ok;
    step_res_t res;
    logic      out_free;
    logic      push, push_last;

    gwwlb_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.rem_start),
        .dividend  (col_reg),
        .divisor   (stop),
        .done      (rem_done),
        .remainder (rem_val)
    );

    always_comb
    begin
        idx_p1    = pos_reg + 1'b1;
        cand_dist = pos_reg - cand_reg;
        stop      = (ts_reg == '0) ? 7'd1 : ts_reg;
        is_nl     = (ch_reg == CHAR_NEWLINE);
        is_tab    = (ch_reg == CHAR_HTAB);
        is_ws     = is_tab || (ch_reg == CHAR_SPACE);
        w         = is_tab ? (8'(stop) - 8'(rem_val)) : 8'd1;
        sum       = 9'(col_reg) + 9'(w);
        fits      = (sum <= 9'(lw_reg));
        soft_ok   = cv_reg && (cand_reg != line_reg);
        hard_ok   = (pos_reg != line_reg);
        if (is_nl)
        begin
            res = RES_END;
        end
        else if (fits)
        begin
            res = RES_FIT;
        end
        else if (soft_ok || hard_ok)
        begin
            res = RES_BREAK;
        end
        else
        begin
            res = RES_END;
        end
        out_free  = !out_valid_reg || out_ready;
        push      = cmd.flush || (cmd.try_step && pend_valid_reg && !is_nl);
        push_last = cmd.flush || (cmd.try_step && fits && !is_nl);
    end

    always_comb
    begin
        st.in_is_tab = (in_character == CHAR_HTAB);
        st.is_tab    = is_tab;
        st.res       = res;
        st.can_push  = !pend_valid_reg || out_free;
        st.out_free  = out_free;
        st.rem_done  = rem_done;
    end

    always_comb
    begin
        pos_next        = pos_reg;
        line_next       = line_reg;
        col_next        = col_reg;
        cand_next       = cand_reg;
        cv_next         = cv_reg;
        ch_next         = ch_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_kind_next  = pend_kind_reg;

        if (cmd.load)
        begin
            ch_next = in_character;
            if (in_first)
            begin
                pos_next  = '0;
                line_next = '0;
                col_next  = '0;
                cand_next = '0;
                cv_next   = 1'b0;
            end
        end

        if (cmd.try_step)
        begin
            if (is_nl)
            begin
                pend_valid_next = 1'b1;
                pend_idx_next   = idx_p1;
                pend_kind_next  = KIND_NEWLINE;
                line_next       = idx_p1;
                col_next        = '0;
                cand_next       = '0;
                cv_next         = 1'b0;
            end
            else if (fits)
            begin
                col_next        = sum[7:0];
                pend_valid_next = 1'b0;
                pos_next        = idx_p1;
                if (is_ws)
                begin
                    cand_next = idx_p1;
                    cv_next   = 1'b1;
                end
            end
            else if (soft_ok)
            begin
                pend_valid_next = 1'b1;
                pend_idx_next   = cand_reg;
                pend_kind_next  = KIND_SOFT;
                line_next       = cand_reg;
                col_next        = cand_dist[7:0];
                cand_next       = '0;
                cv_next         = 1'b0;
            end
            else if (hard_ok)
            begin
                pend_valid_next = 1'b1;
                pend_idx_next   = pos_reg;
                pend_kind_next  = KIND_HARD;
                line_next       = pos_reg;
                col_next        = '0;
                cand_next       = '0;
                cv_next         = 1'b0;
            end
            else
            begin
                pend_valid_next = 1'b1;
                pend_idx_next   = idx_p1;
                pend_kind_next  = KIND_HARD;
                line_next       = idx_p1;
                col_next        = '0;
                cand_next       = '0;
                cv_next         = 1'b0;
            end
        end

        if (cmd.flush)
        begin
            pend_valid_next = 1'b0;
            pos_next        = idx_p1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_idx_next   = out_idx_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_idx_next   = 16'(pend_idx_reg);
            out_kind_next  = pend_kind_reg;
            out_last_next  = push_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_reg         <= LINE_WIDTH_RESET;
            ts_reg         <= TAB_STOP_RESET;
            pos_reg        <= '0;
            line_reg       <= '0;
            col_reg        <= '0;
            cand_reg       <= '0;
            cv_reg         <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LINE_WIDTH: lw_reg <= cfg_wdata;
                    CFG_TAB_STOP:   ts_reg <= cfg_wdata[6:0];
                    default:        lw_reg <= lw_reg;
                endcase
            end
            pos_reg        <= pos_next;
            line_reg       <= line_next;
            col_reg        <= col_next;
            cand_reg       <= cand_next;
            cv_reg         <= cv_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        pend_idx_reg  <= pend_idx_next;
        pend_kind_reg <= pend_kind_next;
        out_idx_reg   <= out_idx_next;
        out_kind_reg  <= out_kind_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_idx_reg;
    assign out_kind  = out_kind_reg;
    assign out_last  = out_last_reg;

    `GWWLB_ASSERT_IMP(a_push_free, push, !out_valid_reg || out_ready, "push into full output")
    `GWWLB_ASSERT_IMP(a_load_clean, cmd.load, !pend_valid_reg, "new char with held break")
    `GWWLB_ASSERT_IMP(a_flush_pend, cmd.flush, pend_valid_reg, "flush without held break")
    `GWWLB_ASSERT_NXT(a_first_rst, cmd.load && in_first, pos_reg == '0, "restart not applied")

endmodule

FILE: hw/rtl/greedy_word_wrap_line_breaker_top.sv
// channel   dir   payload                                           handshake
// in_ch     in    character[7:0], first_of_text                     valid/ready
// out_ch    out   line_start_index[15:0], break_kind[1:0], last_of_run  valid/ready
// cfg       in    cfg_index[0], cfg_wdata[7:0]                      cfg_we
//
// a plain char is accepted, then takes one fit/break step per try
// a tab runs the 2-bit-per-cycle column remainder unit before each try
// each break adds a try (up to 3); newline and lone breaks add a flush
// output is a single register; a held break waits for it, stalling the sequencer
// rst_n clears all line state and loads width 40, tab stop 4
module greedy_word_wrap_line_breaker_top #(
    parameter int INDEX_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    gwwlb_in_if.sink              in_ch,
    gwwlb_out_if.source           out_ch,
    input  logic                  cfg_we,
    input  gwwlb_pkg::cfg_index_t cfg_index,
    input  gwwlb_pkg::cfg_data_t  cfg_wdata
);
    import gwwlb_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t st;
    logic     in_ready;
    logic     out_valid;
    logic [15:0] out_index;
    logic [1:0]  out_kind;
    logic     out_last;

    gwwlb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    gwwlb_dp #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_character (in_ch.character),
        .in_first     (in_ch.first_of_text),
        .out_ready    (out_ch.ready),
        .out_valid    (out_valid),
        .out_index    (out_index),
        .out_kind     (out_kind),
        .out_last     (out_last),
        .cmd          (cmd),
        .st           (st)
    );

    assign in_ch.ready             = in_ready;
    assign out_ch.valid            = out_valid;
    assign out_ch.line_start_index = out_index;
    assign out_ch.break_kind       = out_kind;
    assign out_ch.last_of_run      = out_last;

endmodule

FILE: dv/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gwwlb_pkg::*;

    localparam int SCRIPT_LEN   = 34;
    localparam int QUIET_LIMIT  = 5000;
    localparam int SETTLE_TICKS = 32;
    localparam int IDLE_PCT     = 23;

    typedef struct packed {
        logic [15:0] start_at;
        kind_t       kind;
        logic        last;
    } line_break_t;

    typedef enum logic [1:0] {
        ROW_CHAR,
        ROW_WIDTH,
        ROW_TAB
    } row_op_t;

    typedef struct packed {
        row_op_t     op;
        char_t       data;
        logic        first;
        logic        typed;
        logic [15:0] exp_start;
        kind_t       exp_kind;
    } script_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    cfg_data_t  cfg_wdata;

    gwwlb_in_if  in_ch ();
    gwwlb_out_if out_ch ();

    greedy_word_wrap_line_breaker_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // line state mirrored from the block
    col_t        width_reg;
    tab_t        tab_reg;
    logic [15:0] next_index;
    logic [15:0] line_origin;
    col_t        cols_used;
    logic [15:0] soft_point;
    logic        cand_ok;

    line_break_t step_breaks[$];
    line_break_t pending_breaks[$];

    bit          idling;
    int unsigned bad_count;
    int unsigned chars_sent;
    int unsigned breaks_seen;
    int unsigned kind_count[3];
    int unsigned formats_used;
    int unsigned quiet_cycles;

    script_row_t script [SCRIPT_LEN] = '{
        '{ROW_CHAR,  CHAR_NEWLINE, 1'b1, 1'b1, 16'd1, KIND_NEWLINE},
        '{ROW_CHAR,  8'h61,        1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  CHAR_HTAB,    1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  CHAR_SPACE,   1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  8'hff,        1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_WIDTH, 8'd3,         1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_TAB,   8'd0,         1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  8'h78,        1'b1, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  CHAR_SPACE,   1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  8'h79,        1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  8'h7a,        1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  CHAR_HTAB,    1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  8'h71,        1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_WIDTH, 8'd0,         1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  8'h61,        1'b1, 1'b1, 16'd1, KIND_HARD},
        '{ROW_CHAR,  CHAR_NEWLINE, 1'b0, 1'b1, 16'd2, KIND_NEWLINE},
        '{ROW_CHAR,  CHAR_SPACE,   1'b0, 1'b1, 16'd3, KIND_HARD},
        '{ROW_WIDTH, 8'd255,       1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_TAB,   8'd127,       1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  CHAR_HTAB,    1'b1, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  CHAR_HTAB,    1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  CHAR_HTAB,    1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_WIDTH, 8'd1,         1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_TAB,   8'd64,        1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  CHAR_HTAB,    1'b1, 1'b1, 16'd1, KIND_HARD},
        '{ROW_CHAR,  8'h62,        1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  CHAR_SPACE,   1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  8'h63,        1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_WIDTH, 8'd4,         1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_TAB,   8'd8,         1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  8'h61,        1'b1, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  CHAR_SPACE,   1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  8'h62,        1'b0, 1'b0, 16'd0, KIND_NEWLINE},
        '{ROW_CHAR,  CHAR_HTAB,    1'b0, 1'b0, 16'd0, KIND_NEWLINE}
    };

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic void open_line(logic [15:0] start_at, logic [15:0] used);
        line_origin = start_at;
        cols_used   = used[7:0];
        cand_ok     = 1'b0;
        soft_point  = '0;
    endfunction

    // fills step_breaks with the line starts caused by one character
    function automatic void predict_breaks(char_t c, logic first);
        logic [15:0] idx;
        int unsigned stop;
        int unsigned w;
        bit          placed;
        line_break_t found [3];
        int          n;
        n = 0;
        step_breaks.delete();
        if (first)
        begin
            next_index = '0;
            open_line('0, '0);
        end
        idx    = next_index;
        stop   = (tab_reg == '0) ? 1 : tab_reg;
        placed = (c == CHAR_NEWLINE);
        if (placed)
        begin
            found[n++] = '{idx + 16'd1, KIND_NEWLINE, 1'b0};
            open_line(idx + 16'd1, '0);
        end
        for (int tries = 0; tries < 3 && !placed; tries++)
        begin
            w = (c == CHAR_HTAB) ? stop - (cols_used % stop) : 1;
            if (cols_used + w <= width_reg)
            begin
                cols_used = col_t'(cols_used + w);
                if (c == CHAR_SPACE || c == CHAR_HTAB)
                begin
                    soft_point = idx + 16'd1;
                    cand_ok    = 1'b1;
                end
                placed = 1'b1;
            end
            else if (cand_ok && soft_point != line_origin)
            begin
                found[n++] = '{soft_point, KIND_SOFT, 1'b0};
                open_line(soft_point, idx - soft_point);
            end
            else if (idx != line_origin)
            begin
                found[n++] = '{idx, KIND_HARD, 1'b0};
                open_line(idx, '0);
            end
            else
            begin
                found[n++] = '{idx + 16'd1, KIND_HARD, 1'b0};
                open_line(idx + 16'd1, '0);
                placed = 1'b1;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            found[i].last = (i == n - 1);
            step_breaks.push_back(found[i]);
        end
        next_index = idx + 16'd1;
    endfunction

    function automatic char_t rand_char();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return 8'h61 + 8'($urandom_range(25));
        else if (r < 70)
            return CHAR_SPACE;
        else if (r < 78)
            return CHAR_HTAB;
        else if (r < 83)
            return CHAR_NEWLINE;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_char(char_t c, logic first, logic typed, logic [15:0] exp_start,
                             kind_t exp_kind);
        @(negedge clk);
        while (idling && $urandom_range(99) < IDLE_PCT)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.character     <= c;
        in_ch.first_of_text <= first;
        do @(posedge clk); while (!in_ch.ready);
        chars_sent++;
        predict_breaks(c, first);
        if (typed)
            pending_breaks.push_back('{exp_start, exp_kind, 1'b1});
        else
            foreach (step_breaks[i])
                pending_breaks.push_back(step_breaks[i]);
    endtask

    // drain every expected break, then let a character with no break finish
    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_breaks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t which, cfg_data_t value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (which == CFG_LINE_WIDTH)
            width_reg = value;
        else
            tab_reg = value[6:0];
    endtask

    task automatic set_format(col_t width, tab_t tab);
        wait_idle();
        write_reg(CFG_LINE_WIDTH, width);
        write_reg(CFG_TAB_STOP, cfg_data_t'(tab));
        formats_used++;
    endtask

    task automatic note_mismatch(string what);
        bad_count++;
        if (bad_count <= 10)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    always @(negedge clk)
        out_ch.ready <= !idling || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        line_break_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            breaks_seen++;
            if (pending_breaks.size() == 0)
                note_mismatch($sformatf("unexpected break start=%0d kind=%0d last=%0d",
                    out_ch.line_start_index, out_ch.break_kind, out_ch.last_of_run));
            else
            begin
                want = pending_breaks.pop_front();
                kind_count[want.kind]++;
                if (out_ch.line_start_index !== want.start_at ||
                    out_ch.break_kind !== want.kind || out_ch.last_of_run !== want.last)
                    note_mismatch($sformatf(
                        "expected start=%0d kind=%0d last=%0d, got start=%0d kind=%0d last=%0d",
                        want.start_at, want.kind, want.last, out_ch.line_start_index,
                        out_ch.break_kind, out_ch.last_of_run));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles, %0d breaks outstanding",
                quiet_cycles, pending_breaks.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = CFG_LINE_WIDTH;
        cfg_wdata           = '0;
        in_ch.valid         = 1'b0;
        in_ch.character     = '0;
        in_ch.first_of_text = 1'b0;
        idling              = 1'b1;
        chars_sent          = 0;
        formats_used        = 1;
        width_reg           = LINE_WIDTH_RESET;
        tab_reg             = TAB_STOP_RESET;
        next_index          = '0;
        open_line('0, '0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
        begin
            case (script[i].op)
                ROW_WIDTH:
                begin
                    wait_idle();
                    write_reg(CFG_LINE_WIDTH, script[i].data);
                end
                ROW_TAB:
                begin
                    wait_idle();
                    write_reg(CFG_TAB_STOP, script[i].data);
                    formats_used++;
                end
                default:
                    send_char(script[i].data, script[i].first, script[i].typed,
                        script[i].exp_start, script[i].exp_kind);
            endcase
        end

        for (int p = 0; p < 9; p++)
        begin
            case (p)
                0: set_format(LINE_WIDTH_RESET, TAB_STOP_RESET);
                1: set_format(8'd255, 7'd127);
                2: set_format(8'd0, 7'd0);
                3: set_format(8'd1, 7'd1);
                4: set_format(8'd12, 7'd8);
                8: set_format(8'($urandom_range(255)), 7'($urandom_range(127)));
                default: set_format(8'($urandom_range(2, 30)), 7'($urandom_range(127)));
            endcase
            idling = (p != 0);
            for (int k = 0; k < 38; k++)
                send_char(rand_char(), (k == 0) || ($urandom_range(99) < 3), 1'b0, '0,
                    KIND_NEWLINE);
        end

        wait_idle();
        $display("sent %0d characters under %0d formats, with random gaps on both sides",
            chars_sent, formats_used);
        $display("checked %0d line starts: %0d newline, %0d soft, %0d hard, %0d mismatches",
            breaks_seen, kind_count[KIND_NEWLINE], kind_count[KIND_SOFT],
            kind_count[KIND_HARD], bad_count);
        if (bad_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
